/* hw/rtl/mcms_pkg.sv */
// ----------------------------------------------------------------------------
// Motion centroid mesh smoother package
// Register map indexes and field widths shared by the block.
// ----------------------------------------------------------------------------
package mcms_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_STEP_SIZE      = 3'd0;
  localparam logic [2:0] REG_GRID_COLUMNS   = 3'd1;
  localparam logic [2:0] REG_FRAME_WIDTH    = 3'd2;
  localparam logic [2:0] REG_SPEED_THRESH   = 3'd3;
  localparam logic [2:0] REG_REPORT_MAX     = 3'd4;
  localparam logic [2:0] REG_MIRROR         = 3'd5;
  localparam logic [2:0] REG_SMOOTHING      = 3'd6;
  localparam logic [2:0] REG_STRENGTH       = 3'd7;

  // Accumulator widths.
  localparam int SUM_W  = 32;
  localparam int WSUM_W = 48;

  // Sequencer states.
  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_READ  = 12'b000000000100,
    S_MUL1  = 12'b000000001000,
    S_MUL2  = 12'b000000010000,
    S_SQRT  = 12'b000000100000,
    S_ACC   = 12'b000001000000,
    S_ACC2  = 12'b000010000000,
    S_FIN   = 12'b000100000000,
    S_DIV   = 12'b001000000000,
    S_REP   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

endpackage

/* hw/rtl/motion_centroid_mesh_smoother.sv */
// ----------------------------------------------------------------------------
// Motion centroid mesh smoother
// Smooths a per-cell vertex offset mesh toward scaled optical flow and
// reports the speed-weighted centroid or peak-speed location per frame.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | col, row, flow_x, flow_y, last_cell
//  out     | output    | out_valid/out_stall| offset_x/y, frame_done, report_*
//  cfg     | input     | APB psel/penable   | 8 registers at 4*i
//
// A cell is accepted, its stored offset read, blended and written back; an
// active cell also runs the 16-step square root and adds to the frame sums.
// A last cell passes S_FIN and, unless report_max is set or the speed sum is
// zero, the 48-step centroid divider. An output stall holds the block in its
// last step. After reset the offset memory is cleared; no cell is accepted
// then. The next cell is accepted while a result waits at the output.
module motion_centroid_mesh_smoother #(
  parameter int MAX_CELLS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         col,
  input  logic [7:0]         row,
  input  logic signed [15:0] flow_x,
  input  logic signed [15:0] flow_y,
  input  logic               last_cell,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] offset_x,
  output logic signed [15:0] offset_y,
  output logic               frame_done,
  output logic               report_valid,
  output logic [11:0]        report_x,
  output logic [11:0]        report_y,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int ADDR_W = $clog2(MAX_CELLS);

  // Configuration registers.
  logic [6:0]         step_size;
  logic [8:0]         grid_columns;
  logic [11:0]        frame_width;
  logic [15:0]        speed_threshold;
  logic               report_max;
  logic               mirror;
  logic [8:0]         smoothing_factor;
  logic signed [15:0] distortion_strength;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size           <= 7'd8;
      grid_columns        <= 9'd80;
      frame_width         <= 12'd640;
      speed_threshold     <= 16'd2560;
      report_max          <= 1'b0;
      mirror              <= 1'b0;
      smoothing_factor    <= 9'd253;
      distortion_strength <= 16'sd1024;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        mcms_pkg::REG_STEP_SIZE:    step_size           <= pwdata[6:0];
        mcms_pkg::REG_GRID_COLUMNS: grid_columns        <= pwdata[8:0];
        mcms_pkg::REG_FRAME_WIDTH:  frame_width         <= pwdata[11:0];
        mcms_pkg::REG_SPEED_THRESH: speed_threshold     <= pwdata[15:0];
        mcms_pkg::REG_REPORT_MAX:   report_max          <= pwdata[0];
        mcms_pkg::REG_MIRROR:       mirror              <= pwdata[0];
        mcms_pkg::REG_SMOOTHING:    smoothing_factor    <= pwdata[8:0];
        mcms_pkg::REG_STRENGTH:     distortion_strength <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[4:2])
      mcms_pkg::REG_STEP_SIZE:    prdata = {25'd0, step_size};
      mcms_pkg::REG_GRID_COLUMNS: prdata = {23'd0, grid_columns};
      mcms_pkg::REG_FRAME_WIDTH:  prdata = {20'd0, frame_width};
      mcms_pkg::REG_SPEED_THRESH: prdata = {16'd0, speed_threshold};
      mcms_pkg::REG_REPORT_MAX:   prdata = {31'd0, report_max};
      mcms_pkg::REG_MIRROR:       prdata = {31'd0, mirror};
      mcms_pkg::REG_SMOOTHING:    prdata = {23'd0, smoothing_factor};
      mcms_pkg::REG_STRENGTH:     prdata = {{16{distortion_strength[15]}},
                                            distortion_strength};
      default:                    prdata = 32'd0;
    endcase
  end

  mcms_pkg::state_t state;

  // Offset memory.
  logic [31:0]       mem [MAX_CELLS];
  logic [31:0]       rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [31:0]       mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data <= mem[mem_addr];
  end

  // Latched cell.
  logic [7:0]         col_q, row_q;
  logic signed [15:0] fx_q, fy_q;
  logic               last_q;
  logic [16:0]        idx_q;
  logic               in_store_q;
  logic [ADDR_W:0]    clr_cnt;

  logic [16:0] idx_in;
  assign idx_in = 17'(row * grid_columns) + 17'(col);

  // Smoothing clamp.
  logic [8:0] zc;
  assign zc = (smoothing_factor > 9'd256) ? 9'd256 : smoothing_factor;

  // Blend pipeline registers.
  logic signed [31:0] tx, ty;
  logic signed [25:0] cx, cy;
  logic [31:0]        sqx, sqy, thr2;
  logic signed [15:0] nx, ny;

  logic signed [15:0] cur_x, cur_y;
  assign cur_x = in_store_q ? $signed(rd_data[15:0])  : 16'sd0;
  assign cur_y = in_store_q ? $signed(rd_data[31:16]) : 16'sd0;

  // Accumulate, round half up, floor shift and saturate.
  logic signed [42:0] acc_x, acc_y;
  logic signed [26:0] sh_x, sh_y;
  logic signed [15:0] sat_x, sat_y;
  assign acc_x = 43'(signed'({cx, 8'd0})) + 43'(tx * $signed({1'b0, zc})) + 43'sd32768;
  assign acc_y = 43'(signed'({cy, 8'd0})) + 43'(ty * $signed({1'b0, zc})) + 43'sd32768;
  assign sh_x  = 27'(acc_x >>> 16);
  assign sh_y  = 27'(acc_y >>> 16);
  assign sat_x = (sh_x > 27'sd32767) ? 16'sd32767 :
                 (sh_x < -27'sd32768) ? -16'sd32768 : sh_x[15:0];
  assign sat_y = (sh_y > 27'sd32767) ? 16'sd32767 :
                 (sh_y < -27'sd32768) ? -16'sd32768 : sh_y[15:0];

  logic [32:0] sq_sum;
  assign sq_sum = {1'b0, sqx} + {1'b0, sqy};

  // Square root and positions.
  logic [31:0] sq_n, sq_res, sq_bit;
  logic [3:0]  sq_cnt;
  logic [15:0] px, py;
  logic [30:0] wxp, wyp;

  // Frame accumulators.
  logic [31:0] speed_sum;
  logic [47:0] weighted_x_sum, weighted_y_sum;
  logic [16:0] peak_speed;
  logic [11:0] peak_x, peak_y;

  logic [32:0] ss_add;
  logic [48:0] wx_add, wy_add;
  assign ss_add = {1'b0, speed_sum} + 33'(sq_res[15:0]);
  assign wx_add = {1'b0, weighted_x_sum} + 49'(wxp);
  assign wy_add = {1'b0, weighted_y_sum} + 49'(wyp);

  // Centroid dividers, x and y in lockstep.
  logic [47:0] qx, qy;
  logic [32:0] rx_rem, ry_rem;
  logic [5:0]  div_cnt;
  logic [32:0] rx_sh, ry_sh;
  assign rx_sh = {rx_rem[31:0], qx[47]};
  assign ry_sh = {ry_rem[31:0], qy[47]};

  // Report.
  logic        rep_v;
  logic [11:0] rep_x, rep_y;
  logic [11:0] sel_x, sel_y;
  assign sel_x = report_max ? peak_x : ((qx > 48'd4095) ? 12'd4095 : qx[11:0]);
  assign sel_y = report_max ? peak_y : ((qy > 48'd4095) ? 12'd4095 : qy[11:0]);

  assign in_stall = (state != mcms_pkg::S_IDLE);

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = idx_q[ADDR_W-1:0];
    mem_wdata = {sat_y, sat_x};
    case (state)
      mcms_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt[ADDR_W-1:0];
        mem_wdata = 32'd0;
      end
      mcms_pkg::S_MUL2: mem_we = in_store_q;
      default: ;
    endcase
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= mcms_pkg::S_CLEAR;
      clr_cnt        <= '0;
      out_valid      <= 1'b0;
      speed_sum      <= '0;
      weighted_x_sum <= '0;
      weighted_y_sum <= '0;
      peak_speed     <= '0;
      peak_x         <= '0;
      peak_y         <= '0;
    end else begin
      // The output step reloads the output register itself.
      if (out_valid && !out_stall && state != mcms_pkg::S_OUT) out_valid <= 1'b0;
      case (state)
        mcms_pkg::S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (ADDR_W + 1)'(MAX_CELLS - 1)) state <= mcms_pkg::S_IDLE;
        end
        mcms_pkg::S_IDLE: begin
          if (in_valid) begin
            col_q      <= col;
            row_q      <= row;
            fx_q       <= flow_x;
            fy_q       <= flow_y;
            last_q     <= last_cell;
            idx_q      <= idx_in;
            in_store_q <= (idx_in < 17'(MAX_CELLS));
            state      <= mcms_pkg::S_READ;
          end
        end
        mcms_pkg::S_READ: state <= mcms_pkg::S_MUL1;
        mcms_pkg::S_MUL1: begin
          tx   <= distortion_strength * fx_q;
          ty   <= distortion_strength * fy_q;
          cx   <= cur_x * $signed({1'b0, 9'd256 - zc});
          cy   <= cur_y * $signed({1'b0, 9'd256 - zc});
          sqx  <= 32'(fx_q * fx_q);
          sqy  <= 32'(fy_q * fy_q);
          thr2 <= speed_threshold * speed_threshold;
          px   <= 16'(col_q * step_size) + 16'(step_size >> 1);
          py   <= 16'(row_q * step_size) + 16'(step_size >> 1);
          state <= mcms_pkg::S_MUL2;
        end
        mcms_pkg::S_MUL2: begin
          nx     <= sat_x;
          ny     <= sat_y;
          sq_n   <= sq_sum[31:0];
          sq_res <= '0;
          sq_bit <= 32'h4000_0000;
          sq_cnt <= '0;
          if (sq_sum > {1'b0, thr2}) state <= mcms_pkg::S_SQRT;
          else if (last_q)           state <= mcms_pkg::S_FIN;
          else                       state <= mcms_pkg::S_REP;
        end
        mcms_pkg::S_SQRT: begin
          if (sq_n >= sq_res + sq_bit) begin
            sq_n   <= sq_n - (sq_res + sq_bit);
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt == 4'd15) state <= mcms_pkg::S_ACC;
        end
        mcms_pkg::S_ACC: begin
          wxp   <= 31'(px * sq_res[15:0]);
          wyp   <= 31'(py * sq_res[15:0]);
          state <= mcms_pkg::S_ACC2;
        end
        mcms_pkg::S_ACC2: begin
          speed_sum      <= ss_add[32] ? 32'hFFFF_FFFF : ss_add[31:0];
          weighted_x_sum <= wx_add[48] ? 48'hFFFF_FFFF_FFFF : wx_add[47:0];
          weighted_y_sum <= wy_add[48] ? 48'hFFFF_FFFF_FFFF : wy_add[47:0];
          if (17'(sq_res[15:0]) > peak_speed) begin
            peak_speed <= 17'(sq_res[15:0]);
            peak_x     <= (px > 16'd4095) ? 12'd4095 : px[11:0];
            peak_y     <= (py > 16'd4095) ? 12'd4095 : py[11:0];
          end
          state <= last_q ? mcms_pkg::S_FIN : mcms_pkg::S_REP;
        end
        mcms_pkg::S_FIN: begin
          qx      <= weighted_x_sum;
          qy      <= weighted_y_sum;
          rx_rem  <= '0;
          ry_rem  <= '0;
          div_cnt <= '0;
          state   <= (report_max || speed_sum == '0) ? mcms_pkg::S_REP : mcms_pkg::S_DIV;
        end
        mcms_pkg::S_DIV: begin
          if (rx_sh >= {1'b0, speed_sum}) begin
            rx_rem <= rx_sh - {1'b0, speed_sum};
            qx     <= {qx[46:0], 1'b1};
          end else begin
            rx_rem <= rx_sh;
            qx     <= {qx[46:0], 1'b0};
          end
          if (ry_sh >= {1'b0, speed_sum}) begin
            ry_rem <= ry_sh - {1'b0, speed_sum};
            qy     <= {qy[46:0], 1'b1};
          end else begin
            ry_rem <= ry_sh;
            qy     <= {qy[46:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 6'd47) state <= mcms_pkg::S_REP;
        end
        mcms_pkg::S_REP: begin
          rep_v <= 1'b0;
          rep_x <= '0;
          rep_y <= '0;
          if (last_q) begin
            if (speed_sum != '0) begin
              rep_v <= 1'b1;
              rep_y <= sel_y;
              if (mirror) rep_x <= (sel_x > frame_width) ? 12'd0 : frame_width - sel_x;
              else        rep_x <= sel_x;
            end
            speed_sum      <= '0;
            weighted_x_sum <= '0;
            weighted_y_sum <= '0;
            peak_speed     <= '0;
            peak_x         <= '0;
            peak_y         <= '0;
          end
          state <= mcms_pkg::S_OUT;
        end
        mcms_pkg::S_OUT: begin
          // Load the output register once it is free or being taken.
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            offset_x     <= nx;
            offset_y     <= ny;
            frame_done   <= last_q;
            report_valid <= rep_v;
            report_x     <= rep_x;
            report_y     <= rep_y;
            state        <= mcms_pkg::S_IDLE;
          end
        end
        default: state <= mcms_pkg::S_IDLE;
      endcase
    end
  end

endmodule
